// ===== rtl/core/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg
// shared widths, constants and unit status type for the deadline timer
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int unsigned MUL_W  = 40;  // multiplier operand width
  localparam int unsigned PROD_W = 80;  // multiplier product width
  localparam int unsigned DVD_W  = 72;  // divider dividend / quotient width
  localparam int unsigned DSR_W  = 40;  // divider divisor / remainder width

  localparam logic [39:0] NS_PER_SEC  = 40'd1000000000;
  localparam logic [39:0] NS_PER_MS   = 40'd1000000;
  localparam logic [39:0] NS_PER_US   = 40'd1000;
  localparam logic [71:0] HOUR_NS     = 72'd3600000000000;
  localparam logic [71:0] SECS_MAX    = 72'd18446744073;
  localparam logic [71:0] ROUND_UP    = 72'd999999999;
  localparam logic [31:0] HOUR_SECS   = 32'd3600;

  localparam logic [0:0] MODE_ARM   = 1'b0;
  localparam logic [0:0] REG_RATE   = 1'b0;
  localparam logic [0:0] REG_FREQ   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

endpackage

// ===== rtl/core/deadline_timer_with_remaining.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_with_remaining
// deadline timer: arm from a tick delay, query remaining ns and ticks
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_tready is low from acceptance until
// its result has been taken. The unit conversions run on one bit-serial
// multiplier and one bit-serial divider, sequenced by a state machine. A
// query takes up to 4 divisions and 4 products; an arm adds up to 5
// divisions and 4 products in front. Zero or expired cases skip steps; a
// disarmed or expired query uses neither the multiplier nor the divider.
// ----------------------------------------------------------------------------
module deadline_timer_with_remaining (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // arm_ticks[63:0], now_count[127:64]
  input  logic [0:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // armed[0], rem_ns[64:1], remaining_ticks[128:65]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [20:0] {
    S_IDLE    = 21'd1 << 0,
    S_A_MUL1  = 21'd1 << 1,
    S_A_DIV1  = 21'd1 << 2,
    S_A_SECS  = 21'd1 << 3,
    S_A_US    = 21'd1 << 4,
    S_A_M1    = 21'd1 << 5,
    S_A_M2    = 21'd1 << 6,
    S_A_D2    = 21'd1 << 7,
    S_A_M3    = 21'd1 << 8,
    S_A_D3    = 21'd1 << 9,
    S_Q_START = 21'd1 << 10,
    S_Q_D1    = 21'd1 << 11,
    S_Q_M1    = 21'd1 << 12,
    S_Q_M2    = 21'd1 << 13,
    S_Q_D2    = 21'd1 << 14,
    S_T_START = 21'd1 << 15,
    S_T_D     = 21'd1 << 16,
    S_T_M1    = 21'd1 << 17,
    S_T_M2    = 21'd1 << 18,
    S_T_D2    = 21'd1 << 19,
    S_OUT     = 21'd1 << 20
  } state_t;

  state_t       st_r, st_nxt;
  logic         issued_r, issued_nxt;
  logic [19:0]  rate_r;
  logic [36:0]  freq_r;
  logic [63:0]  dl_r, dl_nxt;
  logic [63:0]  now_r, now_nxt;
  logic [71:0]  x_r, x_nxt;
  logic [63:0]  y_r, y_nxt;
  logic [39:0]  z_r, z_nxt;
  logic [63:0]  ns_r, ns_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [135:0] out_data_r, out_data_nxt;

  logic                    mul_start, div_start, is_mul, is_div;
  logic [39:0]             mul_a, mul_b;
  logic [79:0]             prod;
  logic [71:0]             dvd, quot;
  logic [39:0]             dsr, rem;
  tdt_pkg::unit_st_t       mul_st, div_st;
  logic                    cfg_wr;
  logic [31:0]             hour_ticks;
  logic [63:0]             in_ticks, in_now;
  logic [64:0]             ns_sum;
  logic [39:0]             rate_w, freq_w;
  logic [63:0]             ticks_val;

  assign in_ticks   = in_tdata[63:0];
  assign in_now     = in_tdata[127:64];
  assign rate_w     = {20'd0, rate_r};
  assign freq_w     = {3'd0, freq_r};
  assign hour_ticks = 32'(rate_r) * tdt_pkg::HOUR_SECS;
  assign ns_sum     = {1'b0, y_r} + {1'b0, quot[63:0]};
  assign ticks_val  = y_r + quot[63:0];

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == tdt_pkg::REG_FREQ) ? {27'd0, freq_r} : {44'd0, rate_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= '0;
      freq_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[3] == tdt_pkg::REG_RATE) begin
        rate_r <= cfg_pwdata[19:0];
      end else begin
        freq_r <= cfg_pwdata[36:0];
      end
    end
  end

  // unit operand selection
  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    dvd    = '0;
    dsr    = '0;
    case (st_r)
      S_A_MUL1: begin is_mul = 1'b1; mul_a = y_r[39:0]; mul_b = tdt_pkg::NS_PER_SEC; end
      S_A_DIV1: begin is_div = 1'b1; dvd = x_r; dsr = rate_w; end
      S_A_SECS: begin is_div = 1'b1; dvd = x_r; dsr = tdt_pkg::NS_PER_SEC; end
      S_A_US:   begin is_div = 1'b1; dvd = {32'd0, z_r}; dsr = tdt_pkg::NS_PER_US; end
      S_A_M1:   begin is_mul = 1'b1; mul_a = y_r[39:0]; mul_b = freq_w; end
      S_A_M2:   begin is_mul = 1'b1; mul_a = x_r[39:0]; mul_b = freq_w; end
      S_A_D2:   begin is_div = 1'b1; dvd = x_r; dsr = tdt_pkg::NS_PER_MS; end
      S_A_M3:   begin is_mul = 1'b1; mul_a = z_r; mul_b = freq_w; end
      S_A_D3:   begin is_div = 1'b1; dvd = x_r; dsr = tdt_pkg::NS_PER_SEC; end
      S_Q_D1:   begin is_div = 1'b1; dvd = x_r; dsr = freq_w; end
      S_Q_M1:   begin is_mul = 1'b1; mul_a = y_r[39:0]; mul_b = tdt_pkg::NS_PER_SEC; end
      S_Q_M2:   begin is_mul = 1'b1; mul_a = z_r; mul_b = tdt_pkg::NS_PER_SEC; end
      S_Q_D2:   begin is_div = 1'b1; dvd = x_r; dsr = freq_w; end
      S_T_D:    begin is_div = 1'b1; dvd = {8'd0, ns_r}; dsr = tdt_pkg::NS_PER_SEC; end
      S_T_M1:   begin is_mul = 1'b1; mul_a = y_r[39:0]; mul_b = rate_w; end
      S_T_M2:   begin is_mul = 1'b1; mul_a = z_r; mul_b = rate_w; end
      S_T_D2:   begin is_div = 1'b1; dvd = x_r + tdt_pkg::ROUND_UP; dsr = tdt_pkg::NS_PER_SEC; end
      default:  begin is_mul = 1'b0; end
    endcase
  end

  assign mul_start = is_mul & ~issued_r;
  assign div_start = is_div & ~issued_r;

  tdt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .st    (mul_st)
  );

  tdt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .quot     (quot),
    .rem      (rem),
    .st       (div_st)
  );

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    issued_nxt    = issued_r;
    dl_nxt        = dl_r;
    now_nxt       = now_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    ns_nxt        = ns_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if ((is_mul || is_div) && !issued_r) begin
      issued_nxt = 1'b1;
    end
    if ((is_mul && mul_st.done) || (is_div && div_st.done)) begin
      issued_nxt = 1'b0;
    end
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          now_nxt = in_now;
          y_nxt   = in_ticks;
          if (in_tuser == tdt_pkg::MODE_ARM) begin
            if (rate_r == '0 || in_ticks == '0 || freq_r == '0) begin
              dl_nxt = '0;
              st_nxt = S_Q_START;
            end else if (in_ticks > {32'd0, hour_ticks}) begin
              x_nxt  = tdt_pkg::HOUR_NS;
              st_nxt = S_A_SECS;
            end else begin
              st_nxt = S_A_MUL1;
            end
          end else begin
            st_nxt = S_Q_START;
          end
        end
      end
      S_A_MUL1: if (mul_st.done) begin x_nxt = prod[71:0]; st_nxt = S_A_DIV1; end
      S_A_DIV1: if (div_st.done) begin x_nxt = quot; st_nxt = S_A_SECS; end
      S_A_SECS: if (div_st.done) begin
        y_nxt = quot[63:0]; z_nxt = rem; st_nxt = S_A_US;
      end
      S_A_US: if (div_st.done) begin x_nxt = quot; z_nxt = rem; st_nxt = S_A_M1; end
      S_A_M1: if (mul_st.done) begin y_nxt = prod[63:0]; st_nxt = S_A_M2; end
      S_A_M2: if (mul_st.done) begin x_nxt = prod[71:0]; st_nxt = S_A_D2; end
      S_A_D2: if (div_st.done) begin y_nxt = ticks_val; st_nxt = S_A_M3; end
      S_A_M3: if (mul_st.done) begin x_nxt = prod[71:0]; st_nxt = S_A_D3; end
      S_A_D3: if (div_st.done) begin dl_nxt = now_r + ticks_val; st_nxt = S_Q_START; end
      S_Q_START: begin
        if (dl_r == '0 || freq_r == '0 || now_r >= dl_r) begin
          ns_nxt = '0;
          st_nxt = S_T_START;
        end else begin
          x_nxt  = {8'd0, dl_r - now_r};
          st_nxt = S_Q_D1;
        end
      end
      S_Q_D1: if (div_st.done) begin
        y_nxt = quot[63:0];
        z_nxt = rem;
        if (quot > tdt_pkg::SECS_MAX) begin
          ns_nxt = '1;
          st_nxt = S_T_START;
        end else begin
          st_nxt = S_Q_M1;
        end
      end
      S_Q_M1: if (mul_st.done) begin y_nxt = prod[63:0]; st_nxt = S_Q_M2; end
      S_Q_M2: if (mul_st.done) begin x_nxt = prod[71:0]; st_nxt = S_Q_D2; end
      S_Q_D2: if (div_st.done) begin
        ns_nxt = ns_sum[64] ? '1 : ns_sum[63:0];
        st_nxt = S_T_START;
      end
      S_T_START: begin
        if (ns_r == '0 || rate_r == '0) begin
          out_data_nxt  = {7'd0, 64'd0, ns_r, dl_r != '0};
          out_valid_nxt = 1'b1;
          st_nxt        = S_OUT;
        end else begin
          st_nxt = S_T_D;
        end
      end
      S_T_D: if (div_st.done) begin y_nxt = quot[63:0]; z_nxt = rem; st_nxt = S_T_M1; end
      S_T_M1: if (mul_st.done) begin y_nxt = prod[63:0]; st_nxt = S_T_M2; end
      S_T_M2: if (mul_st.done) begin x_nxt = prod[71:0]; st_nxt = S_T_D2; end
      S_T_D2: if (div_st.done) begin
        out_data_nxt  = {7'd0, ticks_val, ns_r, dl_r != '0};
        out_valid_nxt = 1'b1;
        st_nxt        = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    ns_r       <= ns_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      st_r        <= S_IDLE;
      issued_r    <= 1'b0;
      dl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      issued_r    <= issued_nxt;
      dl_r        <= dl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/tdt_mul.sv =====
// ----------------------------------------------------------------------------
// tdt_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module tdt_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tdt_pkg::MUL_W-1:0]    a,
  input  logic [tdt_pkg::MUL_W-1:0]    b,
  output logic [tdt_pkg::PROD_W-1:0]   prod,
  output tdt_pkg::unit_st_t            st
);

  logic [tdt_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [tdt_pkg::PROD_W-1:0] a_r, a_nxt;
  logic [tdt_pkg::MUL_W-1:0]  b_r, b_nxt;
  logic [5:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = {{(tdt_pkg::PROD_W-tdt_pkg::MUL_W){1'b0}}, a};
      b_nxt    = b;
      cnt_nxt  = 6'(tdt_pkg::MUL_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = {a_r[tdt_pkg::PROD_W-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[tdt_pkg::MUL_W-1:1]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign prod    = acc_r;
  assign st.busy = busy_r;
  assign st.done = done_r;

endmodule

// ===== rtl/core/tdt_div.sv =====
// ----------------------------------------------------------------------------
// tdt_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdt_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tdt_pkg::DVD_W-1:0]    dividend,
  input  logic [tdt_pkg::DSR_W-1:0]    divisor,
  output logic [tdt_pkg::DVD_W-1:0]    quot,
  output logic [tdt_pkg::DSR_W-1:0]    rem,
  output tdt_pkg::unit_st_t            st
);

  logic [tdt_pkg::DVD_W-1:0] q_r, q_nxt;
  logic [tdt_pkg::DSR_W-1:0] r_r, r_nxt;
  logic [tdt_pkg::DSR_W-1:0] d_r, d_nxt;
  logic [6:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [tdt_pkg::DSR_W:0]   trial;
  logic [tdt_pkg::DSR_W:0]   diff;

  assign trial = {r_r, q_r[tdt_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = 7'(tdt_pkg::DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[tdt_pkg::DSR_W]) begin
        r_nxt = diff[tdt_pkg::DSR_W-1:0];
        q_nxt = {q_r[tdt_pkg::DVD_W-2:0], 1'b1};
      end else begin
        r_nxt = trial[tdt_pkg::DSR_W-1:0];
        q_nxt = {q_r[tdt_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot    = q_r;
  assign rem     = r_r;
  assign st.busy = busy_r;
  assign st.done = done_r;

endmodule

// ===== rtl/core/tdt_checker.sv =====
// ----------------------------------------------------------------------------
// tdt_checker
// port-level checks on item flow of the deadline timer
// ----------------------------------------------------------------------------
module tdt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before taken");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input open while result pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("no busy phase after accept");

  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready && !out_tvalid)
    else $error("input not reopened after result");

endmodule

bind deadline_timer_with_remaining tdt_checker u_tdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ===== verif/tb_deadline_timer_with_remaining.sv =====
// ----------------------------------------------------------------------------
// tb_deadline_timer_with_remaining
// checks arm and query results of the deadline timer against a local model,
// over several rate and frequency settings, with random stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_deadline_timer_with_remaining;

  localparam logic [0:0]  MODE_QUERY = 1'b1;
  localparam logic [63:0] NS_SEC     = 64'd1000000000;
  localparam logic [63:0] HR_SECS    = 64'd3600;
  localparam logic [63:0] HR_NS      = 64'd3600000000000;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          IDLE_LIMIT = 20000;
  localparam int          LONG_HOLD  = 3000;

  typedef struct {
    logic [0:0]  mode;
    logic [63:0] ticks;
    logic [63:0] now;
  } cmd_t;

  typedef struct {
    logic        armed;
    logic [63:0] ns;
    logic [63:0] ticks;
  } status_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // arm_ticks[63:0], now_count[127:64]
  logic [0:0]   in_tuser;   // mode
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;  // armed[0], rem_ns[64:1], remaining_ticks[128:65]
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  deadline_timer_with_remaining u_top (.*);

  cmd_t        cmd_q[$];
  status_t     status_q[$];
  cmd_t        cur_cmd;
  logic [63:0] tick_rate;
  logic [63:0] cnt_freq;
  logic [63:0] deadline;
  int          errors;
  int          results;
  int          send_gap;
  int          recv_gap;
  int          hold_cnt;
  bit          hold_done;
  bit          no_idle;
  int          idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] tick_delay_ns(logic [63:0] t, logic [63:0] rate);
    if (rate == 0) return 0;
    if (t > HR_SECS * rate) return HR_NS;
    return (t / rate) * NS_SEC + ((t % rate) * NS_SEC) / rate;
  endfunction

  function automatic logic [63:0] ns_to_cycles(logic [63:0] ns, logic [63:0] f);
    logic [63:0] n;
    logic [63:0] frac;
    if (f == 0) return 0;
    n = (ns > HR_NS) ? HR_NS : ns;
    frac = n % NS_SEC;
    return (n / NS_SEC) * f + ((frac / 1000) * f) / 1000000 + ((frac % 1000) * f) / NS_SEC;
  endfunction

  function automatic logic [63:0] frac_to_ns(logic [63:0] r, logic [63:0] f);
    logic [63:0] q;
    logic [63:0] t;
    q = 0;
    for (int i = 0; i < 3; i++) begin
      t = r * 1000;
      q = q * 1000 + t / f;
      r = t % f;
    end
    return q;
  endfunction

  function automatic logic [63:0] ns_until(logic [63:0] now);
    logic [63:0] span;
    logic [63:0] secs;
    logic [63:0] whole;
    logic [63:0] part;
    if (deadline == 0 || cnt_freq == 0 || now >= deadline) return 0;
    span = deadline - now;
    secs = span / cnt_freq;
    if (secs > ALL_ONES / NS_SEC) return ALL_ONES;
    whole = secs * NS_SEC;
    part = frac_to_ns(span % cnt_freq, cnt_freq);
    if (part > ALL_ONES - whole) return ALL_ONES;
    return whole + part;
  endfunction

  function automatic logic [63:0] ns_to_ticks_ceil(logic [63:0] ns);
    if (ns == 0 || tick_rate == 0) return 0;
    return (ns / NS_SEC) * tick_rate + ((ns % NS_SEC) * tick_rate + NS_SEC - 1) / NS_SEC;
  endfunction

  function automatic status_t timer_step(cmd_t c);
    status_t s;
    if (c.mode == tdt_pkg::MODE_ARM) begin
      if (tick_rate == 0 || c.ticks == 0 || cnt_freq == 0)
        deadline = 0;
      else
        deadline = c.now + ns_to_cycles(tick_delay_ns(c.ticks, tick_rate), cnt_freq);
    end
    s.ns = ns_until(c.now);
    s.armed = (deadline != 0);
    s.ticks = ns_to_ticks_ceil(s.ns);
    return s;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on item %0d: %s got %0h want %0h", results, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      send_gap  <= 0;
    end else if (in_tvalid) begin
      if (in_tready) begin
        status_q.push_back(timer_step(cur_cmd));
        in_tvalid <= 1'b0;
        send_gap  <= no_idle ? 0 : $urandom_range(0, 10);
      end
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
    end else if (cmd_q.size() > 0) begin
      cur_cmd   = cmd_q.pop_front();
      in_tdata  <= {cur_cmd.now, cur_cmd.ticks};
      in_tuser  <= cur_cmd.mode;
      in_tvalid <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    status_t e;
    int n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
      results    <= 0;
    end else if (out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        $display("result with no expectation waiting");
        errors++;
      end else begin
        e = status_q.pop_front();
        if (out_tdata[0] !== e.armed) report("armed", out_tdata[0], e.armed);
        if (out_tdata[64:1] !== e.ns) report("rem_ns", out_tdata[64:1], e.ns);
        if (out_tdata[128:65] !== e.ticks)
          report("remaining_ticks", out_tdata[128:65], e.ticks);
      end
      results <= results + 1;
      n = no_idle ? 0 : $urandom_range(0, 10);
      recv_gap   <= n;
      out_tready <= (n == 0) && (hold_cnt <= 1);
    end else begin
      if (recv_gap > 0) recv_gap <= recv_gap - 1;
      out_tready <= (recv_gap <= 1) && (hold_cnt <= 1);
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results == 40) begin
      hold_cnt  <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** deadline_timer_with_remaining: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 4'(idx) * 4'd8;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == tdt_pkg::REG_RATE) tick_rate = {44'd0, val[19:0]};
    else cnt_freq = {27'd0, val[36:0]};
  endtask

  task automatic set_rates(logic [63:0] rate, logic [63:0] freq);
    reg_write(tdt_pkg::REG_RATE, rate);
    reg_write(tdt_pkg::REG_FREQ, freq);
  endtask

  task automatic push_cmd(logic [0:0] mode, logic [63:0] t, logic [63:0] now);
    cmd_t c;
    c.mode = mode;
    c.ticks = t;
    c.now = now;
    cmd_q.push_back(c);
  endtask

  // sampled at the falling edge so that driver updates have settled
  task automatic drain();
    do begin
      @(negedge clk);
    end while (cmd_q.size() != 0 || in_tvalid || status_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_items(int count);
    logic [63:0] t;
    logic [63:0] now;
    logic [63:0] cyc;
    logic [63:0] off;
    int k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 4))
          0: t = $urandom_range(1, 5000);
          1: t = HR_SECS * tick_rate + $urandom_range(0, 2) - 1;
          2: t = rand64();
          3: t = 0;
          default: t = $urandom_range(1, 1 << 20);
        endcase
        now = rand64();
        push_cmd(tdt_pkg::MODE_ARM, t, now);
        k++;
        cyc = (t == 0) ? 0 : ns_to_cycles(tick_delay_ns(t, tick_rate), cnt_freq);
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 5))
            0: off = 0;
            1: off = cyc - 1;
            2: off = cyc;
            3: off = cyc + 1;
            4: off = (cyc == 0) ? 0 : rand64() % cyc;
            default: off = rand64();
          endcase
          push_cmd(MODE_QUERY, rand64(), now + off);
          k++;
        end
      end else begin
        push_cmd(1'($urandom), rand64(), rand64());
        k++;
      end
    end
  endtask

  initial begin
    logic [63:0] r;
    logic [63:0] f;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tick_rate   = 0;
    cnt_freq    = 0;
    deadline    = 0;
    errors      = 0;
    no_idle     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: everything disarmed
    push_cmd(tdt_pkg::MODE_ARM, 64'd5, 64'd100);
    push_cmd(MODE_QUERY, ALL_ONES, 64'd0);
    drain();

    set_rates(64'd1000, 64'd1000000000);
    push_cmd(tdt_pkg::MODE_ARM, 64'd0, ALL_ONES);
    push_cmd(tdt_pkg::MODE_ARM, 64'd1, 64'd0);
    push_cmd(MODE_QUERY, 64'd0, 64'd999999);
    push_cmd(MODE_QUERY, 64'd0, 64'd1000000);
    push_cmd(MODE_QUERY, 64'd0, 64'd2000000);
    push_cmd(tdt_pkg::MODE_ARM, ALL_ONES, 64'd12345);
    push_cmd(tdt_pkg::MODE_ARM, 64'd3600000, 64'd7);
    push_cmd(tdt_pkg::MODE_ARM, 64'd3600001, 64'd7);
    push_cmd(tdt_pkg::MODE_ARM, 64'd1, ALL_ONES - 64'd999999);
    push_cmd(MODE_QUERY, 64'd0, 64'd0);
    push_cmd(tdt_pkg::MODE_ARM, 64'd7, ALL_ONES);
    push_cmd(MODE_QUERY, ALL_ONES, 64'd3);
    drain();

    set_rates(64'd1, 64'd1);
    push_cmd(tdt_pkg::MODE_ARM, 64'd1, 64'h8000_0000_0000_0000);
    push_cmd(MODE_QUERY, 64'd0, 64'd0);
    drain();

    set_rates(64'd1000000, 64'd100000000000);
    push_cmd(MODE_QUERY, 64'd0, 64'd0);
    push_cmd(tdt_pkg::MODE_ARM, 64'd1, 64'd0);
    push_cmd(MODE_QUERY, 64'd0, 64'd1);
    drain();

    set_rates(64'd0, 64'd100000000000);
    push_cmd(MODE_QUERY, 64'd0, 64'd0);
    push_cmd(tdt_pkg::MODE_ARM, 64'd9, 64'd0);
    drain();
    set_rates(64'd1000, 64'd0);
    push_cmd(tdt_pkg::MODE_ARM, 64'd9, 64'd0);
    drain();

    for (int p = 0; p < 7; p++) begin
      no_idle = (p == 3);
      case (p)
        0: begin r = 1000; f = 1000000000; end
        1: begin r = 1000000; f = 100000000000; end
        2: begin r = 1; f = 1; end
        3: begin r = $urandom_range(1, 1000000); f = $urandom_range(1, 1000); end
        4: begin r = $urandom_range(1, 1000000); f = rand64() % 100000000001; end
        5: begin r = 0; f = rand64() % 100000000001; end
        default: begin r = 1000000; f = 0; end
      endcase
      set_rates(r, f);
      random_items(95);
      drain();
    end

    repeat (1200) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("** deadline_timer_with_remaining: PASSED **");
    end else begin
      $display("** deadline_timer_with_remaining: FAILED **");
    end
    $finish;
  end

endmodule
